### rtl/core/u2cd_pkg.sv
// Shared constants and helpers for the Unix time to civil date converter.
package u2cd_pkg;

	// Pipeline depth, one valid bit per stage.
	localparam int NSTG = 12;

	// Fixed local offset of eight hours, in seconds.
	localparam logic [31:0] LOCAL_OFFSET = 32'd28800;

	// Day split: floor(2^32 / 86400) as reciprocal.
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [15:0] DAY_RECIP    = 16'd49710;

	// Era selection. Shifted day counts only reach eras 4 and 5, so the
	// boundary is a fixed day count and the day of era is an offset add.
	localparam logic [15:0] ERA5_DAYS    = 16'd11017;
	localparam logic [17:0] ERA4_DOE_OFS = 18'd135080;
	localparam logic [11:0] ERA4_YEAR    = 12'd1600;
	localparam logic [11:0] ERA5_YEAR    = 12'd2000;

	// Year of era: reciprocals floor(2^18 / 1460) and floor(2^18 / 365).
	localparam logic [10:0] DAYS_4Y      = 11'd1460;
	localparam logic [7:0]  RECIP_1460   = 8'd179;
	localparam logic [17:0] DAYS_100Y    = 18'd36524;
	localparam logic [17:0] LAST_DOE     = 18'd146096;
	localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
	localparam logic [9:0]  RECIP_365    = 10'd718;

	// Time of day: reciprocals floor(2^17 / 3600) and floor(2^12 / 60).
	localparam logic [11:0] SECS_PER_HR  = 12'd3600;
	localparam logic [5:0]  RECIP_3600   = 6'd36;
	localparam logic [5:0]  SECS_PER_MIN = 6'd60;
	localparam logic [6:0]  RECIP_60     = 7'd68;

	// Month index from March; index 10 and up roll into the next year.
	localparam logic [3:0]  MP_JANUARY   = 4'd10;
	localparam logic [3:0]  MONTHS_MAR   = 4'd12;

	// Hour and minute carried together down the delay stages.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
	} tod_t;

	// First day of year (March based) of each month index.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] res;
		case (mp)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd61;
			4'd3:    res = 9'd92;
			4'd4:    res = 9'd122;
			4'd5:    res = 9'd153;
			4'd6:    res = 9'd184;
			4'd7:    res = 9'd214;
			4'd8:    res = 9'd245;
			4'd9:    res = 9'd275;
			4'd10:   res = 9'd306;
			4'd11:   res = 9'd337;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

### rtl/core/u2cd_time_of_day.sv
// Seconds of the day to local hour and minute, stages four through twelve.
module u2cd_time_of_day (
	input  logic                       clk,
	input  logic [u2cd_pkg::NSTG-1:0]  en,
	input  logic [16:0]                sod_s3,
	output logic [4:0]                 hour_of_day,
	output logic [5:0]                 minute_of_hour
);

	logic [16:0]        sod_s4;
	logic [4:0]         hour_s4;
	logic [4:0]         hour_s5;
	logic [11:0]        rem_s5;
	logic [4:0]         hour_s6;
	logic [11:0]        rem_s6;
	logic [5:0]         min_s6;
	u2cd_pkg::tod_t     tod_s7;
	u2cd_pkg::tod_t     tod_s8;
	u2cd_pkg::tod_t     tod_s9;
	u2cd_pkg::tod_t     tod_s10;
	u2cd_pkg::tod_t     tod_s11;
	u2cd_pkg::tod_t     tod_s12;

	logic [22:0]        hr_prod;
	logic [16:0]        hr_rem;
	logic [18:0]        mn_prod;
	logic [11:0]        mn_rem;

	// Hour estimate by reciprocal multiply; may be one low.
	assign hr_prod = sod_s3 * {17'd0, u2cd_pkg::RECIP_3600};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sod_s4  <= sod_s3;
			hour_s4 <= hr_prod[21:17];
		end
	end

	// Remainder and one-step correction of the hour.
	always_comb begin
		hr_rem = sod_s4 - 17'(hour_s4 * u2cd_pkg::SECS_PER_HR);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			if (hr_rem >= 17'(u2cd_pkg::SECS_PER_HR)) begin
				hour_s5 <= hour_s4 + 5'd1;
				rem_s5  <= 12'(hr_rem - 17'(u2cd_pkg::SECS_PER_HR));
			end else begin
				hour_s5 <= hour_s4;
				rem_s5  <= hr_rem[11:0];
			end
		end
	end

	// Minute estimate by reciprocal multiply.
	assign mn_prod = rem_s5 * {12'd0, u2cd_pkg::RECIP_60};

	always_ff @(posedge clk) begin
		if (en[5]) begin
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			min_s6  <= mn_prod[17:12];
		end
	end

	// Minute correction.
	assign mn_rem = rem_s6 - 12'(min_s6 * u2cd_pkg::SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			tod_s7.hour   <= hour_s6;
			tod_s7.minute <= (mn_rem >= 12'(u2cd_pkg::SECS_PER_MIN)) ? min_s6 + 6'd1 : min_s6;
		end
	end

	// Delay stages to line up with the date path.
	always_ff @(posedge clk) begin
		if (en[7]) begin
			tod_s8 <= tod_s7;
		end
		if (en[8]) begin
			tod_s9 <= tod_s8;
		end
		if (en[9]) begin
			tod_s10 <= tod_s9;
		end
		if (en[10]) begin
			tod_s11 <= tod_s10;
		end
		if (en[11]) begin
			tod_s12 <= tod_s11;
		end
	end

	assign hour_of_day    = tod_s12.hour;
	assign minute_of_hour = tod_s12.minute;

endmodule

### rtl/core/u2cd_days_to_civil.sv
// Day count since 1970 to Gregorian year, month and day, stages four through twelve.
module u2cd_days_to_civil (
	input  logic                       clk,
	input  logic [u2cd_pkg::NSTG-1:0]  en,
	input  logic [15:0]                days_s3,
	output logic [11:0]                year,
	output logic [3:0]                 month,
	output logic [4:0]                 day_of_month
);

	logic [17:0] doe_s4;
	logic [11:0] ybase_s4;
	logic [17:0] doe_s5;
	logic [11:0] ybase_s5;
	logic [7:0]  q4y_s5;
	logic [2:0]  q100_s5;
	logic        qlast_s5;
	logic [17:0] doe_s6;
	logic [11:0] ybase_s6;
	logic [7:0]  q4y_s6;
	logic [2:0]  q100_s6;
	logic        qlast_s6;
	logic [17:0] doe_s7;
	logic [11:0] ybase_s7;
	logic [17:0] n_s7;
	logic [17:0] doe_s8;
	logic [11:0] ybase_s8;
	logic [17:0] n_s8;
	logic [8:0]  yoe_s8;
	logic [17:0] doe_s9;
	logic [11:0] ybase_s9;
	logic [8:0]  yoe_s9;
	logic [8:0]  doy_s10;
	logic [11:0] yfull_s10;
	logic [8:0]  doy_s11;
	logic [11:0] yfull_s11;
	logic [3:0]  mp_s11;
	logic [11:0] year_s12;
	logic [3:0]  month_s12;
	logic [4:0]  day_s12;

	logic        era5;
	logic [25:0] q4y_prod;
	logic [2:0]  q100_cnt;
	logic [17:0] q4y_rem;
	logic [27:0] yoe_prod;
	logic [17:0] yoe_rem;
	logic [1:0]  c100;
	logic [17:0] yr_days;
	logic [3:0]  mp_cnt;
	logic [8:0]  dom_m1;

	// Era and day of era.
	assign era5 = (days_s3 >= u2cd_pkg::ERA5_DAYS);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			if (era5) begin
				doe_s4   <= {2'b00, days_s3} - {2'b00, u2cd_pkg::ERA5_DAYS};
				ybase_s4 <= u2cd_pkg::ERA5_YEAR;
			end else begin
				doe_s4   <= {2'b00, days_s3} + u2cd_pkg::ERA4_DOE_OFS;
				ybase_s4 <= u2cd_pkg::ERA4_YEAR;
			end
		end
	end

	// Four-year estimate by reciprocal; century and last-day terms by compare.
	assign q4y_prod = doe_s4 * {18'd0, u2cd_pkg::RECIP_1460};

	always_comb begin
		q100_cnt = 3'd0;
		for (int i = 1; i <= 4; i++) begin
			if (doe_s4 >= 18'(u2cd_pkg::DAYS_100Y * 18'(i))) begin
				q100_cnt = q100_cnt + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			doe_s5   <= doe_s4;
			ybase_s5 <= ybase_s4;
			q4y_s5   <= q4y_prod[25:18];
			q100_s5  <= q100_cnt;
			qlast_s5 <= (doe_s4 == u2cd_pkg::LAST_DOE);
		end
	end

	// Correct the four-year quotient.
	assign q4y_rem = doe_s5 - 18'(q4y_s5 * u2cd_pkg::DAYS_4Y);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			doe_s6   <= doe_s5;
			ybase_s6 <= ybase_s5;
			q4y_s6   <= (q4y_rem >= 18'(u2cd_pkg::DAYS_4Y)) ? q4y_s5 + 8'd1 : q4y_s5;
			q100_s6  <= q100_s5;
			qlast_s6 <= qlast_s5;
		end
	end

	// Day of era with leap days folded out.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			doe_s7   <= doe_s6;
			ybase_s7 <= ybase_s6;
			n_s7     <= doe_s6 - {10'd0, q4y_s6} + {15'd0, q100_s6} - {17'd0, qlast_s6};
		end
	end

	// Year of era estimate by reciprocal.
	assign yoe_prod = n_s7 * {18'd0, u2cd_pkg::RECIP_365};

	always_ff @(posedge clk) begin
		if (en[7]) begin
			doe_s8   <= doe_s7;
			ybase_s8 <= ybase_s7;
			n_s8     <= n_s7;
			yoe_s8   <= yoe_prod[26:18];
		end
	end

	// Correct the year of era.
	assign yoe_rem = n_s8 - 18'(yoe_s8 * u2cd_pkg::DAYS_PER_YR);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			doe_s9   <= doe_s8;
			ybase_s9 <= ybase_s8;
			yoe_s9   <= (yoe_rem >= 18'(u2cd_pkg::DAYS_PER_YR)) ? yoe_s8 + 9'd1 : yoe_s8;
		end
	end

	// Day of the March-based year and the full year.
	always_comb begin
		c100 = 2'd0;
		for (int i = 1; i <= 3; i++) begin
			if (yoe_s9 >= 9'(100 * i)) begin
				c100 = c100 + 2'd1;
			end
		end
		yr_days = 18'(yoe_s9 * u2cd_pkg::DAYS_PER_YR) + {11'd0, yoe_s9[8:2]} - {16'd0, c100};
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			doy_s10   <= 9'(doe_s9 - yr_days);
			yfull_s10 <= ybase_s9 + {3'd0, yoe_s9};
		end
	end

	// Month index from the month start table.
	always_comb begin
		mp_cnt = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s10 >= u2cd_pkg::month_start(4'(i))) begin
				mp_cnt = mp_cnt + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			doy_s11   <= doy_s10;
			yfull_s11 <= yfull_s10;
			mp_s11    <= mp_cnt;
		end
	end

	// Calendar month, day of month and the January/February year roll.
	assign dom_m1 = doy_s11 - u2cd_pkg::month_start(mp_s11);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			day_s12 <= dom_m1[4:0] + 5'd1;
			if (mp_s11 >= u2cd_pkg::MP_JANUARY) begin
				month_s12 <= mp_s11 + 4'd3 - u2cd_pkg::MONTHS_MAR;
				year_s12  <= yfull_s11 + 12'd1;
			end else begin
				month_s12 <= mp_s11 + 4'd3;
				year_s12  <= yfull_s11;
			end
		end
	end

	assign year         = year_s12;
	assign month        = month_s12;
	assign day_of_month = day_s12;

endmodule

### rtl/core/unix_time_to_civil_date.sv
// Top level: Unix seconds to local civil date and time, with pipeline control.
//
// Converts a 32-bit Unix timestamp, shifted by a fixed eight-hour local
// offset (wrapping at 2^32), into Gregorian year, month, day, hour and
// minute. The pipeline is 12 register stages deep, and one timestamp can
// be taken in every cycle unless all stages are full and the output side
// is stalled. The depth comes from the chain of divisions by constants,
// each done as a reciprocal multiply followed by a one-step correction in
// the next stage. Each stage holds its own valid bit and loads whenever it
// is empty or its content moves on, so empty stages fill in behind a
// stalled output and nothing is dropped or repeated.
module unix_time_to_civil_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] unix_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour
);

	logic [u2cd_pkg::NSTG-1:0] vld_q;
	logic [u2cd_pkg::NSTG-1:0] en;

	logic [31:0] local_s1;
	logic [31:0] local_s2;
	logic [15:0] days_e_s2;
	logic [15:0] days_s3;
	logic [16:0] sod_s3;

	logic [47:0] day_prod;
	logic [31:0] day_rem;

	// A stage loads when it is empty or its content moves on this cycle.
	always_comb begin
		en[u2cd_pkg::NSTG-1] = !vld_q[u2cd_pkg::NSTG-1] || out_ready;
		for (int i = u2cd_pkg::NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < u2cd_pkg::NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[u2cd_pkg::NSTG-1];

	// Local time, wrapping at 2^32.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			local_s1 <= unix_seconds + u2cd_pkg::LOCAL_OFFSET;
		end
	end

	// Day count estimate by reciprocal multiply; may be one low.
	assign day_prod = local_s1 * {32'd0, u2cd_pkg::DAY_RECIP};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			local_s2  <= local_s1;
			days_e_s2 <= day_prod[47:32];
		end
	end

	// Remainder and one-step correction give days and seconds of the day.
	assign day_rem = local_s2 - 32'(days_e_s2 * u2cd_pkg::SECS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (day_rem >= 32'(u2cd_pkg::SECS_PER_DAY)) begin
				days_s3 <= days_e_s2 + 16'd1;
				sod_s3  <= 17'(day_rem - 32'(u2cd_pkg::SECS_PER_DAY));
			end else begin
				days_s3 <= days_e_s2;
				sod_s3  <= day_rem[16:0];
			end
		end
	end

	// Date path.
	u2cd_days_to_civil u_date (
		.clk          (clk),
		.en           (en),
		.days_s3      (days_s3),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	// Time of day path.
	u2cd_time_of_day u_tod (
		.clk            (clk),
		.en             (en),
		.sod_s3         (sod_s3),
		.hour_of_day    (hour_of_day),
		.minute_of_hour (minute_of_hour)
	);

endmodule
